// File: rtl/core/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and codes for the first-fit one-or-two slot allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   // Field widths of the transaction channels
   localparam int ACTION_W    = 1;
   localparam int KIND_W      = 2;
   localparam int ID_W        = 8;
   localparam int SLOT_W      = 6;
   localparam int STATUS_W    = 3;
   localparam int FREE_W      = 7;
   localparam int CFG_W       = 7;
   localparam int CSR_INDEX_W = 4;
   localparam int PRODUCT_W   = 2 * CFG_W;

   // Request actions
   localparam logic [ACTION_W-1:0] ACTION_ALLOC   = 1'b0;
   localparam logic [ACTION_W-1:0] ACTION_RELEASE = 1'b1;

   // Vehicle kinds
   localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PAIR   = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_ROOM     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_KIND    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RELEASED    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RELEASE = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SLOTS_PER_FLOOR = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FLOOR_COUNT     = 4'd1;

   // Register reset values
   localparam logic [CFG_W-1:0] SLOTS_PER_FLOOR_RESET = 7'd8;
   localparam logic [CFG_W-1:0] FLOOR_COUNT_RESET     = 7'd1;

   // One entry of the slot store
   typedef struct packed {
      logic            occupied;
      logic [ID_W-1:0] owner;
   } slot_entry_type;

   // Configuration view handed from the register block to the core
   typedef struct packed {
      logic [CFG_W-1:0]     spf_eff;
      logic [PRODUCT_W-1:0] slot_product;
      logic                 reload;
   } cfg_status_type;

endpackage

// File: rtl/core/ffsa_if.sv
// ----------------------------------------------------------------------------
// ffsa_if
// Valid/ready channels of the slot allocator: request, response, registers.
// ----------------------------------------------------------------------------
interface ffsa_req_if;
   logic                          valid;
   logic                          ready;
   logic [ffsa_pkg::ACTION_W-1:0] action;
   logic [ffsa_pkg::KIND_W-1:0]   vehicle_kind;
   logic [ffsa_pkg::ID_W-1:0]     vehicle_id;
   logic [ffsa_pkg::SLOT_W-1:0]   slot;

   modport source (output valid, action, vehicle_kind, vehicle_id, slot, input ready);
   modport sink   (input valid, action, vehicle_kind, vehicle_id, slot, output ready);
endinterface

interface ffsa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffsa_pkg::STATUS_W-1:0] status;
   logic [ffsa_pkg::SLOT_W-1:0]   slot_res;
   logic [ffsa_pkg::FREE_W-1:0]   free_slots;

   modport source (output valid, status, slot_res, free_slots, input ready);
   modport sink   (input valid, status, slot_res, free_slots, output ready);
endinterface

interface ffsa_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ffsa_pkg::CSR_INDEX_W-1:0] index;
   logic [ffsa_pkg::CFG_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/ffsa_cfg.sv
// ----------------------------------------------------------------------------
// ffsa_cfg
// Configuration registers: floor length, floor count and the slot product.
// ----------------------------------------------------------------------------
module ffsa_cfg (
   input  logic                     clock,
   input  logic                     reset,
   ffsa_csr_if.sink                 csr_chan,
   output ffsa_pkg::cfg_status_type cfg
);

   logic [ffsa_pkg::CFG_W-1:0] spf_ff, spf_in;
   logic [ffsa_pkg::CFG_W-1:0] fc_ff, fc_in;
   logic                       reload_ff, reload_in;
   logic [ffsa_pkg::CFG_W-1:0] spf_eff;

   // Always take register writes
   assign csr_chan.ready = 1'b1;

   // Decode the register index, flag a reload on a known register
   always_comb begin
      spf_in    = spf_ff;
      fc_in     = fc_ff;
      reload_in = 1'b0;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            ffsa_pkg::REG_SLOTS_PER_FLOOR: begin
               spf_in    = csr_chan.data;
               reload_in = 1'b1;
            end
            ffsa_pkg::REG_FLOOR_COUNT: begin
               fc_in     = csr_chan.data;
               reload_in = 1'b1;
            end
            default: begin
               reload_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spf_ff    <= ffsa_pkg::SLOTS_PER_FLOOR_RESET;
         fc_ff     <= ffsa_pkg::FLOOR_COUNT_RESET;
         reload_ff <= 1'b1;
      end else begin
         spf_ff    <= spf_in;
         fc_ff     <= fc_in;
         reload_ff <= reload_in;
      end
   end

   // A zero floor length acts as one slot per floor
   assign spf_eff = (spf_ff == '0) ? ffsa_pkg::CFG_W'(1) : spf_ff;

   assign cfg.spf_eff      = spf_eff;
   assign cfg.slot_product = ffsa_pkg::PRODUCT_W'(spf_eff) * ffsa_pkg::PRODUCT_W'(fc_ff);
   assign cfg.reload       = reload_ff;

endmodule

// File: rtl/core/first_fit_one_or_two_slot_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_one_or_two_slot_allocator
// First-fit allocator of single slots and adjacent slot pairs over floors.
// ----------------------------------------------------------------------------
// The block serves one request at a time. An allocate transaction scans the
// slot store one slot per cycle through the single read port of the slot
// memory, over total = min(slots_per_floor * floor_count, MAX_SLOTS) slots;
// a pair hit claims the upper slot, then the lower one in S_WR_LO. A release
// reads the named slot, then its neighbor, and frees the neighbor too when
// the same owner holds it; an empty slot is refused. A bad kind, an early
// no-room or an out-of-range release skip the store. After reset and after
// every write to a known register the store is swept clean, one entry per
// cycle, over all MAX_SLOTS entries; no request is taken during that sweep,
// register writes are. The response sits in an output register, so a new
// request may enter while the last response waits.
// ----------------------------------------------------------------------------
module first_fit_one_or_two_slot_allocator #(
   parameter int MAX_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   ffsa_req_if.sink    req_chan,
   ffsa_rsp_if.source  rsp_chan,
   ffsa_csr_if.sink    csr_chan
);

   localparam int AW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int XW = (CW > 7) ? CW : 7;

   // Sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN     = 4'd1;
   localparam logic [3:0] S_WR_LO    = 4'd2;
   localparam logic [3:0] S_REL_RD   = 4'd3;
   localparam logic [3:0] S_REL_CHK  = 4'd4;
   localparam logic [3:0] S_REL_NEXT = 4'd5;
   localparam logic [3:0] S_FINISH   = 4'd6;

   ffsa_pkg::cfg_status_type cfg;

   logic [3:0]                     state_ff, state_in;
   logic                           clr_ff, clr_in;
   logic [AW-1:0]                  clr_addr_ff, clr_addr_in;
   logic [CW-1:0]                  total_ff, total_in;
   logic [CW-1:0]                  free_ff, free_in;
   logic [ffsa_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [ffsa_pkg::ID_W-1:0]      id_ff, id_in;
   logic [ffsa_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [CW-1:0]                  scan_ff, scan_in;
   logic [ffsa_pkg::CFG_W-1:0]     issue_pos_ff, issue_pos_in;
   logic [AW-1:0]                  chk_ff, chk_in;
   logic [ffsa_pkg::CFG_W-1:0]     chk_pos_ff, chk_pos_in;
   logic                           chk_valid_ff, chk_valid_in;
   logic                           prev_free_ff, prev_free_in;
   ffsa_pkg::slot_entry_type       held_ff, held_in;
   logic [ffsa_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [ffsa_pkg::SLOT_W-1:0]    res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ffsa_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ffsa_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [ffsa_pkg::FREE_W-1:0]    rsp_free_ff, rsp_free_in;

   ffsa_pkg::slot_entry_type       slot_mem [MAX_SLOTS];
   ffsa_pkg::slot_entry_type       rd_data_ff;
   logic [AW-1:0]                  mem_raddr;
   logic                           mem_we;
   logic [AW-1:0]                  mem_waddr;
   ffsa_pkg::slot_entry_type       mem_wdata;

   logic [CW-1:0]                  cap_total;
   logic                           req_fire;
   logic                           rsp_free;
   logic                           scan_hit;
   logic [ffsa_pkg::CFG_W-1:0]     pos_next;
   logic                           next_owned;

   // Register block
   ffsa_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // Cap the configured slot count at the store size
   assign cap_total = (32'(cfg.slot_product) > 32'(MAX_SLOTS)) ?
                      CW'(MAX_SLOTS) : CW'(cfg.slot_product);

   assign req_chan.ready = (state_ff == S_IDLE) && !clr_ff && !cfg.reload;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.slot_res   = rsp_slot_ff;
   assign rsp_chan.free_slots = rsp_free_ff;

   // Hit test on the entry that came back from the store
   always_comb begin
      if (kind_ff == ffsa_pkg::KIND_SINGLE) begin
         scan_hit = chk_valid_ff && !rd_data_ff.occupied;
      end else begin
         scan_hit = chk_valid_ff && !rd_data_ff.occupied && prev_free_ff &&
                    (chk_pos_ff != '0);
      end
   end

   // Floor position of the next slot to read
   assign pos_next = (issue_pos_ff + ffsa_pkg::CFG_W'(1) == cfg.spf_eff) ?
                     '0 : issue_pos_ff + ffsa_pkg::CFG_W'(1);

   // The neighbor is freed with the slot when the same owner holds it
   assign next_owned = (XW'(slot_ff) + XW'(1) < XW'(total_ff)) &&
                       rd_data_ff.occupied && (rd_data_ff.owner == held_ff.owner);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      clr_addr_in   = clr_addr_ff;
      total_in      = total_ff;
      free_in       = free_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      slot_in       = slot_ff;
      scan_in       = scan_ff;
      issue_pos_in  = issue_pos_ff;
      chk_in        = chk_ff;
      chk_pos_in    = chk_pos_ff;
      chk_valid_in  = chk_valid_ff;
      prev_free_in  = prev_free_ff;
      held_in       = held_ff;
      status_in     = status_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_free_in   = rsp_free_ff;
      mem_raddr     = AW'(slot_ff);
      mem_we        = 1'b0;
      mem_waddr     = chk_ff;
      mem_wdata     = '{occupied: 1'b1, owner: id_ff};

      unique case (state_ff)
         S_IDLE: begin
            mem_raddr = AW'(req_chan.slot);
            if (req_fire) begin
               kind_in = req_chan.vehicle_kind;
               id_in   = req_chan.vehicle_id;
               slot_in = req_chan.slot;
               res_in  = '0;
               if (req_chan.action == ffsa_pkg::ACTION_ALLOC) begin
                  if (req_chan.vehicle_kind != ffsa_pkg::KIND_SINGLE &&
                      req_chan.vehicle_kind != ffsa_pkg::KIND_PAIR) begin
                     status_in = ffsa_pkg::STATUS_BAD_KIND;
                     state_in  = S_FINISH;
                  end else if (XW'(free_ff) < XW'(req_chan.vehicle_kind)) begin
                     status_in = ffsa_pkg::STATUS_NO_ROOM;
                     state_in  = S_FINISH;
                  end else begin
                     scan_in      = '0;
                     issue_pos_in = '0;
                     chk_valid_in = 1'b0;
                     prev_free_in = 1'b0;
                     state_in     = S_SCAN;
                  end
               end else begin
                  res_in = req_chan.slot;
                  if (XW'(req_chan.slot) >= XW'(total_ff)) begin
                     status_in = ffsa_pkg::STATUS_BAD_RELEASE;
                     state_in  = S_FINISH;
                  end else begin
                     state_in = S_REL_RD;
                  end
               end
            end
         end

         S_SCAN: begin
            mem_raddr = scan_ff[AW-1:0];
            if (scan_hit) begin
               // Claim the slot that just came back
               mem_we    = 1'b1;
               mem_waddr = chk_ff;
               status_in = ffsa_pkg::STATUS_ALLOCATED;
               if (kind_ff == ffsa_pkg::KIND_SINGLE) begin
                  free_in  = free_ff - CW'(1);
                  res_in   = ffsa_pkg::SLOT_W'(chk_ff);
                  state_in = S_FINISH;
               end else begin
                  res_in   = ffsa_pkg::SLOT_W'(chk_ff - AW'(1));
                  state_in = S_WR_LO;
               end
            end else begin
               if (chk_valid_ff) begin
                  prev_free_in = !rd_data_ff.occupied;
               end
               if (scan_ff < total_ff) begin
                  // Issue the next read
                  scan_in      = scan_ff + CW'(1);
                  chk_in       = scan_ff[AW-1:0];
                  chk_pos_in   = issue_pos_ff;
                  issue_pos_in = pos_next;
                  chk_valid_in = 1'b1;
               end else begin
                  chk_valid_in = 1'b0;
                  if (!chk_valid_ff) begin
                     status_in = ffsa_pkg::STATUS_NO_ROOM;
                     res_in    = '0;
                     state_in  = S_FINISH;
                  end
               end
            end
         end

         S_WR_LO: begin
            // Claim the lower slot of the pair
            mem_we    = 1'b1;
            mem_waddr = chk_ff - AW'(1);
            free_in   = free_ff - CW'(2);
            state_in  = S_FINISH;
         end

         S_REL_RD: begin
            // Entry of the named slot arrives, read its neighbor
            held_in   = rd_data_ff;
            mem_raddr = AW'(XW'(slot_ff) + XW'(1));
            state_in  = S_REL_CHK;
         end

         S_REL_CHK: begin
            if (!held_ff.occupied) begin
               status_in = ffsa_pkg::STATUS_BAD_RELEASE;
               state_in  = S_FINISH;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = AW'(slot_ff);
               mem_wdata = '{occupied: 1'b0, owner: held_ff.owner};
               free_in   = free_ff + CW'(1);
               status_in = ffsa_pkg::STATUS_RELEASED;
               state_in  = next_owned ? S_REL_NEXT : S_FINISH;
            end
         end

         S_REL_NEXT: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(XW'(slot_ff) + XW'(1));
            mem_wdata = '{occupied: 1'b0, owner: held_ff.owner};
            free_in   = free_ff + CW'(1);
            state_in  = S_FINISH;
         end

         S_FINISH: begin
            // Hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = res_ff;
               rsp_free_in   = ffsa_pkg::FREE_W'(free_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Sweep the store clean after reset and after a write to a known register
      if (clr_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '{occupied: 1'b0, owner: '0};
         if (clr_addr_ff == AW'(MAX_SLOTS - 1)) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end
      if (cfg.reload) begin
         clr_in      = 1'b1;
         clr_addr_in = '0;
         total_in    = cap_total;
         free_in     = cap_total;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         total_ff     <= '0;
         free_ff      <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         total_ff     <= total_in;
         free_ff      <= free_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      slot_ff       <= slot_in;
      scan_ff       <= scan_in;
      issue_pos_ff  <= issue_pos_in;
      chk_ff        <= chk_in;
      chk_pos_ff    <= chk_pos_in;
      prev_free_ff  <= prev_free_in;
      held_ff       <= held_in;
      status_ff     <= status_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // Slot store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[mem_raddr];
   end

endmodule
